/* sv/itad_pkg.sv */
package itad_pkg;

    localparam int C_DIGITS    = 16;
    localparam int C_BIN_W     = 32;
    localparam int C_CNT_W     = 5;

    typedef logic [3:0] t_nibble;
    typedef logic [7:0] t_char;
    typedef logic [C_CNT_W-1:0] t_cnt;

    // conversion commands
    localparam logic [2:0] CMD_SDEC  = 3'd0;
    localparam logic [2:0] CMD_UDEC  = 3'd1;
    localparam logic [2:0] CMD_HEXL  = 3'd2;
    localparam logic [2:0] CMD_HEXU  = 3'd3;
    localparam logic [2:0] CMD_PTR   = 3'd4;

    localparam t_char   C_ASCII_ZERO  = 8'h30;
    localparam t_char   C_ASCII_LOWA  = 8'h61;
    localparam t_char   C_ASCII_UPA   = 8'h41;
    localparam t_nibble C_TEN         = 4'd10;
    localparam t_nibble C_DABBLE_LIM  = 4'd5;
    localparam t_nibble C_DABBLE_ADJ  = 4'd3;

    localparam t_cnt C_DABBLE_LAST = t_cnt'(C_BIN_W - 1);
    localparam t_cnt C_EMIT_LAST   = t_cnt'(C_DIGITS - 1);

    // what each digit cell does in a cycle
    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } t_cell_ctrl;

    function automatic t_char f_digit_char(input t_nibble d, input logic upper);
        t_char base;
        base = upper ? C_ASCII_UPA : C_ASCII_LOWA;
        if (d < C_TEN) begin
            f_digit_char = C_ASCII_ZERO + t_char'(d);
        end else begin
            f_digit_char = base + t_char'(d - C_TEN);
        end
    endfunction

endpackage

/* sv/integer_to_ascii_digits.sv */
// A zero value or an unused command gives its single result in the cycle after start.
// Hex and pointer: the cells load the nibbles, busy stays high while the row shifts out;
// digits arrive one per cycle, leading zeros dropped.
// Decimal: double dabble of the magnitude through the digit cells, then the emit phase.
// While the 16-cell digit row works on a non-zero item, busy is high and no new item is taken.
// Reset (i_rst_n low, synchronous) returns to idle and drops any item; no receiver stall.
module integer_to_ascii_digits (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [63:0] i_value,
    input  logic        i_precision_given,
    input  logic        i_precision_nonzero,
    output logic        o_valid,
    output logic [7:0]  o_digit_char,
    output logic        o_is_last,
    output logic        o_is_empty,
    output logic        o_negative,
    output logic        o_alt_prefix_dropped
);
    import itad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DABBLE = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt;
    logic [C_BIN_W-1:0] r_bin, n_bin;
    logic   r_seen, n_seen;
    logic   r_upper, n_upper;
    logic   r_neg, n_neg;

    logic   r_valid, n_valid;
    t_char  r_char, n_char;
    logic   r_last, n_last;
    logic   r_empty, n_empty;
    logic   r_oneg, n_oneg;
    logic   r_drop, n_drop;

    t_cell_ctrl w_ctrl;
    t_nibble    w_digit [C_DIGITS];
    logic       w_carry [C_DIGITS];
    t_nibble    w_load  [C_DIGITS];

    logic               w_accept;
    logic               w_is_hex;
    logic [C_BIN_W-1:0] w_word;
    logic [C_BIN_W-1:0] w_mag32;
    logic               w_sign;
    logic               w_zero;
    t_nibble            w_top;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign w_top    = w_digit[C_DIGITS-1];

    // Hex modes load the nibbles straight into the cells; decimal loads zeros
    // and shifts the magnitude in one bit a cycle.
    assign w_is_hex = (i_cmd == CMD_HEXL) || (i_cmd == CMD_HEXU) || (i_cmd == CMD_PTR);
    assign w_word   = i_value[C_BIN_W-1:0];
    assign w_sign   = (i_cmd == CMD_SDEC) && w_word[C_BIN_W-1];
    assign w_mag32  = w_sign ? (~w_word + 1'b1) : w_word;
    assign w_zero   = w_is_hex ? (i_value == 64'd0) : (w_word == '0);

    genvar gi;
    generate
        for (gi = 0; gi < C_DIGITS; gi++) begin : g_cell
            assign w_load[gi] = w_is_hex ? i_value[4*gi +: 4] : '0;
            if (gi == 0) begin : g_first
                itad_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (w_ctrl),
                    .i_load_digit (w_load[gi]),
                    .i_bit_in     (r_bin[C_BIN_W-1]),
                    .i_digit_in   (t_nibble'(0)),
                    .o_bit_out    (w_carry[gi]),
                    .o_digit      (w_digit[gi])
                );
            end else begin : g_rest
                itad_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (w_ctrl),
                    .i_load_digit (w_load[gi]),
                    .i_bit_in     (w_carry[gi-1]),
                    .i_digit_in   (w_digit[gi-1]),
                    .o_bit_out    (w_carry[gi]),
                    .o_digit      (w_digit[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_seen  = r_seen;
        n_upper = r_upper;
        n_neg   = r_neg;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        n_empty = r_empty;
        n_oneg  = r_oneg;
        n_drop  = r_drop;
        w_ctrl  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority if (i_cmd > CMD_PTR) begin
                        // unused command: one empty result
                        n_valid = 1'b1;
                        n_char  = '0;
                        n_last  = 1'b1;
                        n_empty = 1'b1;
                        n_oneg  = 1'b0;
                        n_drop  = 1'b0;
                    end else if (w_zero) begin
                        // zero: '0', or empty when a zero precision was given outside pointer mode
                        n_valid = 1'b1;
                        n_last  = 1'b1;
                        n_oneg  = 1'b0;
                        n_drop  = (i_cmd == CMD_HEXL) || (i_cmd == CMD_HEXU);
                        if ((i_cmd == CMD_PTR) || !i_precision_given
                                || i_precision_nonzero) begin
                            n_char  = C_ASCII_ZERO;
                            n_empty = 1'b0;
                        end else begin
                            n_char  = '0;
                            n_empty = 1'b1;
                        end
                    end else begin
                        w_ctrl.load = 1'b1;
                        n_bin   = w_mag32;
                        n_cnt   = '0;
                        n_seen  = 1'b0;
                        n_upper = (i_cmd == CMD_HEXU);
                        n_neg   = w_sign;
                        n_state = w_is_hex ? S_EMIT : S_DABBLE;
                    end
                end
            end
            S_DABBLE: begin
                // advance one binary bit into the BCD row
                w_ctrl.dabble = 1'b1;
                n_bin = {r_bin[C_BIN_W-2:0], 1'b0};
                if (r_cnt == C_DABBLE_LAST) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EMIT: begin
                // move the row up one digit; drop leading zeros
                w_ctrl.shift = 1'b1;
                if (r_seen || (w_top != '0)) begin
                    n_seen  = 1'b1;
                    n_valid = 1'b1;
                    n_char  = f_digit_char(w_top, r_upper);
                    n_last  = (r_cnt == C_EMIT_LAST);
                    n_empty = 1'b0;
                    n_oneg  = r_neg;
                    n_drop  = 1'b0;
                end
                if (r_cnt == C_EMIT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_seen  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_seen  <= n_seen;
            r_valid <= n_valid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_upper <= n_upper;
        r_neg   <= n_neg;
        r_char  <= n_char;
        r_last  <= n_last;
        r_empty <= n_empty;
        r_oneg  <= n_oneg;
        r_drop  <= n_drop;
    end

    assign o_valid              = r_valid;
    assign o_digit_char         = r_char;
    assign o_is_last            = r_last;
    assign o_is_empty           = r_empty;
    assign o_negative           = r_oneg;
    assign o_alt_prefix_dropped = r_drop;

endmodule

/* sv/itad_cell.sv */
module itad_cell (
    input  logic                   i_clk,
    input  itad_pkg::t_cell_ctrl   i_ctrl,
    input  itad_pkg::t_nibble      i_load_digit,
    input  logic                   i_bit_in,
    input  itad_pkg::t_nibble      i_digit_in,
    output logic                   o_bit_out,
    output itad_pkg::t_nibble      o_digit
);
    import itad_pkg::*;

    t_nibble r_digit;
    t_nibble w_adj;

    // add three before the shift so the BCD digit carries correctly
    always_comb begin
        w_adj     = (r_digit >= C_DABBLE_LIM) ? r_digit + C_DABBLE_ADJ : r_digit;
        o_bit_out = w_adj[3];
        o_digit   = r_digit;
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.load) begin
            r_digit <= i_load_digit;
        end else if (i_ctrl.dabble) begin
            r_digit <= {w_adj[2:0], i_bit_in};
        end else if (i_ctrl.shift) begin
            r_digit <= i_digit_in;
        end
    end

endmodule

/* bench/tb_integer_to_ascii_digits.sv */
module tb_integer_to_ascii_digits;
    import itad_pkg::*;

    // Command codes past pointer hex have no conversion behind them; each gives
    // a single empty result.
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    // Run limit in clock cycles, set far above the slowest correct run of about
    // 150 items with sender gaps between bursts.
    localparam int RUN_LIMIT    = 200000;
    localparam int TAIL_CYCLES  = 60;
    localparam int RANDOM_ITEMS = 120;

    // One ASCII digit result as the block presents it
    typedef struct packed {
        t_char digit_char;
        logic  is_last;
        logic  is_empty;
        logic  negative;
        logic  alt_prefix_dropped;
    } t_digit_rec;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_cmd;
    logic [63:0] i_value;
    logic        i_precision_given;
    logic        i_precision_nonzero;
    logic        o_valid;
    logic [7:0]  o_digit_char;
    logic        o_is_last;
    logic        o_is_empty;
    logic        o_negative;
    logic        o_alt_prefix_dropped;

    // Digits still owed by the block, oldest first
    t_digit_rec pending_digits[$];
    int         err_count;
    int         cycle_count;

    integer_to_ascii_digits dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_cmd                (i_cmd),
        .i_value              (i_value),
        .i_precision_given    (i_precision_given),
        .i_precision_nonzero  (i_precision_nonzero),
        .o_valid              (o_valid),
        .o_digit_char         (o_digit_char),
        .o_is_last            (o_is_last),
        .o_is_empty           (o_is_empty),
        .o_negative           (o_negative),
        .o_alt_prefix_dropped (o_alt_prefix_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Work out the digit string for one item and queue it, most significant
    // digit first. Decimal modes look at the low word only; signed decimal
    // converts the magnitude and flags the sign on every digit.
    function automatic void convert_to_digits(input logic [2:0] cmd, input logic [63:0] value,
                                              input logic prec_given, input logic prec_nonzero);
        logic [31:0] word;
        logic [63:0] mag;
        logic        neg;
        logic        dropped;
        t_char       digits[C_DIGITS];
        int          n;
        string       tab;
        neg     = 1'b0;
        dropped = 1'b0;
        n       = 0;
        if (cmd > CMD_PTR) begin
            pending_digits.push_back(t_digit_rec'{8'h00, 1'b1, 1'b1, 1'b0, 1'b0});
            return;
        end
        case (cmd)
            CMD_SDEC: begin
                word = value[31:0];
                if (word[31]) begin
                    neg  = 1'b1;
                    word = -word;
                end
                mag = {32'h0, word};
            end
            CMD_UDEC: mag = {32'h0, value[31:0]};
            default:  mag = value;
        endcase
        // Zero: one digit, or one empty result when precision zero was asked for.
        // The pointer form always prints its zero and never drops a prefix.
        if (mag == 64'h0) begin
            dropped = (cmd == CMD_HEXL) || (cmd == CMD_HEXU);
            if (cmd == CMD_PTR || !prec_given || prec_nonzero) begin
                pending_digits.push_back(t_digit_rec'{C_ASCII_ZERO, 1'b1, 1'b0, neg, dropped});
            end else begin
                pending_digits.push_back(t_digit_rec'{8'h00, 1'b1, 1'b1, neg, dropped});
            end
            return;
        end
        if (cmd == CMD_SDEC || cmd == CMD_UDEC) begin
            while (mag != 64'h0 && n < C_DIGITS) begin
                digits[n] = C_ASCII_ZERO + t_char'(mag % 64'd10);
                mag       = mag / 64'd10;
                n++;
            end
        end else begin
            tab = (cmd == CMD_HEXU) ? "0123456789ABCDEF" : "0123456789abcdef";
            while (mag != 64'h0 && n < C_DIGITS) begin
                digits[n] = tab[mag[3:0]];
                mag       = mag >> 4;
                n++;
            end
        end
        for (int k = n - 1; k >= 0; k--) begin
            pending_digits.push_back(t_digit_rec'{digits[k], k == 0, 1'b0, neg, dropped});
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] expected,
                                        input logic [7:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, expected, actual);
            err_count++;
        end
    endfunction

    // Check every strobed result against the oldest digit still owed. The
    // receiver cannot hold results off, so there is nothing to stall here.
    always @(posedge i_clk) begin
        t_digit_rec exp_rec;
        if (i_rst_n && o_valid) begin
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected result, expected none, got char %h last %b empty %b",
                         $time, o_digit_char, o_is_last, o_is_empty);
                err_count++;
            end else begin
                exp_rec = pending_digits.pop_front();
                check_field("digit_char", exp_rec.digit_char, o_digit_char);
                check_field("is_last", 8'(exp_rec.is_last), 8'(o_is_last));
                check_field("is_empty", 8'(exp_rec.is_empty), 8'(o_is_empty));
                check_field("negative", 8'(exp_rec.negative), 8'(o_negative));
                check_field("alt_prefix_dropped", 8'(exp_rec.alt_prefix_dropped),
                            8'(o_alt_prefix_dropped));
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Present one item from the falling edge and hold it until a rising edge
    // sees busy low. Start stays high afterwards, so a follow-on item can go
    // straight out at the next falling edge.
    task automatic send_item(input logic [2:0] cmd, input logic [63:0] value,
                             input logic prec_given, input logic prec_nonzero);
        @(negedge i_clk);
        start               <= 1'b1;
        i_cmd               <= cmd;
        i_value             <= value;
        i_precision_given   <= prec_given;
        i_precision_nonzero <= prec_nonzero;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        convert_to_digits(cmd, value, prec_given, prec_nonzero);
    endtask

    // Drop start for a number of cycles
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Drop start and wait for every owed digit to come out
    task automatic drain_digits();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_digits.size() != 0) @(negedge i_clk);
    endtask

    // Signed decimal: sign handling, the most negative word, zero with and
    // without a zero precision, and high bits that must be ignored.
    task automatic test_signed_decimal();
        send_item(CMD_SDEC, 64'h0, 1'b0, 1'b0);
        send_item(CMD_SDEC, 64'h0, 1'b1, 1'b0);
        send_item(CMD_SDEC, 64'hDEAD_BEEF_0000_0000, 1'b1, 1'b1);
        send_item(CMD_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0);
        send_item(CMD_SDEC, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0);
        send_item(CMD_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b1, 1'b1);
        send_item(CMD_SDEC, 64'h0000_0000_FFFF_FFFB, 1'b1, 1'b0);
    endtask

    task automatic test_unsigned_decimal();
        send_item(CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_item(CMD_UDEC, 64'h1234_5678_0000_0000, 1'b1, 1'b0);
        send_item(CMD_UDEC, 64'h0000_0000_0000_0001, 1'b1, 1'b0);
        send_item(CMD_UDEC, 64'h0000_0000_8000_0000, 1'b0, 1'b1);
    endtask

    // Hex in both cases: full sixteen-digit values, every digit, and zero
    // dropping the prefix with and without an empty result.
    task automatic test_hex();
        send_item(CMD_HEXL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_item(CMD_HEXL, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
        send_item(CMD_HEXL, 64'h0, 1'b0, 1'b0);
        send_item(CMD_HEXL, 64'h0, 1'b1, 1'b0);
        send_item(CMD_HEXU, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b1);
        send_item(CMD_HEXU, 64'h0, 1'b1, 1'b1);
    endtask

    // Pointer zero prints a digit whatever the precision says
    task automatic test_pointer();
        send_item(CMD_PTR, 64'h0, 1'b1, 1'b0);
        send_item(CMD_PTR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_item(CMD_PTR, 64'h8000_0000_0000_0000, 1'b1, 1'b1);
    endtask

    task automatic test_unused_commands();
        for (int c = int'(CMD_RSVD_LO); c <= int'(CMD_RSVD_HI); c++) begin
            send_item(3'(c), {$urandom, $urandom}, 1'(c), 1'(c >> 1));
        end
    endtask

    // Value shapes that hit short and long digit strings, zero, and the
    // word boundaries that matter to the decimal modes.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       v = 64'h0;
            1:       v = 64'($urandom_range(1, 99));
            2:       v = v >> $urandom_range(0, 63);
            3: begin
                case ($urandom_range(0, 2))
                    0:       v[31:0] = 32'h8000_0000;
                    1:       v[31:0] = 32'h7FFF_FFFF;
                    default: v[31:0] = 32'hFFFF_FFFF;
                endcase
            end
            4:       v[31:0] = 32'h0;
            default: ;
        endcase
        return v;
    endfunction

    // Random items in bursts with random gaps, long enough at times to land
    // on every phase of a decimal conversion; drain now and again.
    task automatic test_random_items();
        int          burst_left;
        logic [2:0]  cmd;
        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                if ($urandom_range(0, 5) != 0) hold_off($urandom_range(1, 60));
            end
            burst_left--;
            if ($urandom_range(0, 9) == 0) begin
                cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            end else begin
                cmd = 3'($urandom_range(CMD_SDEC, CMD_PTR));
            end
            send_item(cmd, random_value(), 1'($urandom), 1'($urandom));
            if (i % 40 == 39) drain_digits();
        end
    endtask

    initial begin
        err_count           = 0;
        cycle_count         = 0;
        i_rst_n             = 1'b0;
        start               = 1'b0;
        i_cmd               = CMD_SDEC;
        i_value             = 64'h0;
        i_precision_given   = 1'b0;
        i_precision_nonzero = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_signed_decimal();
        test_unsigned_decimal();
        drain_digits();
        test_hex();
        test_pointer();
        test_unused_commands();
        drain_digits();
        test_random_items();

        // Let the last conversion finish, then look for stray results
        drain_digits();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_count == 0 && pending_digits.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
